FILE: sv/alt_pkg.sv
// Shared types and codes for the address lease table.
// Used by alt_cell, address_lease_table_core and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package alt_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_SOLICIT = 2'd0;
	localparam logic [1:0] KIND_REQUEST = 2'd1;
	localparam logic [1:0] KIND_TICK    = 2'd2;

	// Result kinds.
	localparam logic [1:0] RK_ADVERTISE = 2'd0;
	localparam logic [1:0] RK_REPLY     = 2'd1;
	localparam logic [1:0] RK_NAK       = 2'd2;
	localparam logic [1:0] RK_EXHAUSTED = 2'd3;

	// Configuration register indexes.
	localparam logic [7:0] CFG_POOL_SIZE = 8'd0;
	localparam logic [7:0] CFG_GRANT     = 8'd1;
	localparam logic [7:0] CFG_BASE      = 8'd2;
	localparam logic [7:0] CFG_OWN_HOST  = 8'd3;

	// Lifetime limits.
	localparam logic [7:0] LIFE_REFRESH_CAP = 8'd254;
	localparam logic [7:0] LIFE_PERMANENT   = 8'hff;

	// Operation carried by a token along the cell row.
	typedef enum logic [1:0] {
		OP_PROBE,
		OP_INSERT,
		OP_REFRESH,
		OP_TICK
	} alt_op_t;

	// Control part of a token; host and lifetime travel beside it.
	typedef struct packed {
		logic    valid;
		alt_op_t op;
		logic    hit;
		logic    saw_free;
	} alt_tok_ctl_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_DRAIN,
		ST_REQ_ISSUE,
		ST_REQ_WAIT,
		ST_RESULT
	} alt_state_t;

endpackage

FILE: sv/alt_cell.sv
// One table entry of the lease row, with the token stage that passes it on.
// Depends on alt_pkg for the token and operation types.
`timescale 1ns / 1ps

module alt_cell #(
	parameter int HOST_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  alt_pkg::alt_tok_ctl_t prev_ctl,
	input  logic [HOST_BITS-1:0]  prev_host,
	input  logic [7:0]            prev_life,
	output alt_pkg::alt_tok_ctl_t next_ctl,
	output logic [HOST_BITS-1:0]  next_host,
	output logic [7:0]            next_life
);
	import alt_pkg::*;

	logic                 valid_q;
	logic [HOST_BITS-1:0] host_q;
	logic [7:0]           life_q;
	alt_tok_ctl_t         ctl_q;
	logic [HOST_BITS-1:0] tok_host_q;
	logic [7:0]           tok_life_q;

	logic         match;
	alt_tok_ctl_t ctl_d;
	logic         valid_d;
	logic         host_we;
	logic [7:0]   life_d;
	logic         life_we;

	assign match = valid_q && (host_q == prev_host);

	// Act on the passing token and build the version handed to the next cell.
	always_comb begin
		ctl_d   = prev_ctl;
		valid_d = valid_q;
		host_we = 1'b0;
		life_d  = life_q;
		life_we = 1'b0;
		if (prev_ctl.valid) begin
			unique case (prev_ctl.op)
				OP_PROBE: begin
					if (match) begin
						ctl_d.hit = 1'b1;
					end
					if (!valid_q) begin
						ctl_d.saw_free = 1'b1;
					end
				end
				OP_INSERT: begin
					if (!prev_ctl.hit && !valid_q) begin
						valid_d   = 1'b1;
						host_we   = 1'b1;
						life_d    = prev_life;
						life_we   = 1'b1;
						ctl_d.hit = 1'b1;
					end
				end
				OP_REFRESH: begin
					if (!prev_ctl.hit && match) begin
						ctl_d.hit = 1'b1;
						if (life_q < LIFE_REFRESH_CAP) begin
							life_d  = life_q + 8'd1;
							life_we = 1'b1;
						end
					end
				end
				OP_TICK: begin
					if (valid_q) begin
						if (life_q <= 8'd1) begin
							valid_d = 1'b0;
						end else if (life_q != LIFE_PERMANENT) begin
							life_d  = life_q - 8'd1;
							life_we = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Entry valid bit and token control stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ctl_q   <= '0;
		end else begin
			valid_q <= valid_d;
			ctl_q   <= ctl_d;
		end
	end

	// Entry contents and token payload stage.
	always_ff @(posedge clk) begin
		if (host_we) begin
			host_q <= prev_host;
		end
		if (life_we) begin
			life_q <= life_d;
		end
		tok_host_q <= prev_host;
		tok_life_q <= prev_life;
	end

	assign next_ctl  = ctl_q;
	assign next_host = tok_host_q;
	assign next_life = tok_life_q;

endmodule

FILE: sv/address_lease_table_core.sv
// Top level of the address lease table: sequencer, registers and the cell row.
// Depends on alt_pkg and alt_cell.
`timescale 1ns / 1ps

// Usage. Items arrive on the in_valid/in_ready channel (kind, client_id,
// req_addr_low); results leave on out_valid/out_ready. Registers are written
// on the cfg_valid/cfg_ready channel, which is always ready, and should only
// be written while the block is idle.
// The lease entries sit in a row of TABLE_DEPTH cells. Every operation is a
// token that enters cell 0 and moves one cell per cycle through the row.
// A tick is taken at the input and yields no result. A request is answered
// from its refresh token once that token leaves the row, or directly,
// without a pass through the row, when it names the server's own ID or lies
// outside the host range. A solicit issues up to TABLE_DEPTH + 1 probes, one
// per cycle, stopping once a free ID is found or the table is seen full, and
// waits for all issued probes to leave the row before its result is made.
// A new item is taken once the previous one has left the sequencer; a
// finished result waits in a holding register while the output register is
// stalled, and the input is not taken again until it has moved on.
// Reset empties the table, sets the ID pointer to 1 and loads the register
// reset values.

module address_lease_table_core #(
	parameter int TABLE_DEPTH = 64,
	parameter int HOST_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [47:0] client_id,
	input  logic [63:0] req_addr_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  reply_kind,
	output logic [47:0] reply_client,
	output logic [63:0] reply_addr_low,
	output logic [15:0] reply_host,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import alt_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 2);
	localparam logic [CW-1:0] PROBE_MAX = CW'(TABLE_DEPTH + 1);

	// Configuration registers.
	logic [15:0] pool_size_q;
	logic [7:0]  grant_q;
	logic [63:0] base_q;
	logic [15:0] own_q;

	// Sequencer state.
	alt_state_t           state_q, state_d;
	logic [HOST_BITS-1:0] next_host_q;
	logic [HOST_BITS-1:0] cand_q;
	logic [CW-1:0]        issued_q, exited_q;
	logic                 found_q, exhaust_q;
	logic [HOST_BITS-1:0] found_host_q;
	logic [47:0]          client_q;
	logic [63:0]          req_q, diff_q;
	logic [1:0]           res_kind_q;
	logic [63:0]          res_addr_q;
	logic [15:0]          res_host_q;
	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [47:0]          out_client_q;
	logic [63:0]          out_addr_q;
	logic [15:0]          out_host_q;

	// Cell row links; entry 0 is the issue point, the last is the row exit.
	alt_tok_ctl_t         link_ctl  [TABLE_DEPTH+1];
	logic [HOST_BITS-1:0] link_host [TABLE_DEPTH+1];
	logic [7:0]           link_life [TABLE_DEPTH+1];

	alt_tok_ctl_t         iss_ctl;
	logic [HOST_BITS-1:0] iss_host;
	logic [7:0]           iss_life;
	alt_tok_ctl_t         exit_ctl;
	logic [HOST_BITS-1:0] exit_host;

	logic [31:0]          pool_w, own_w;
	logic [HOST_BITS-1:0] pool_raw, eff_pool, own_h, start_host;
	logic                 own_nz, own_probe_hit;
	logic                 in_xfer, drained, adv_ok, result_move;
	logic                 probe_exit, refresh_exit;
	logic                 req_own, req_out_of_range, req_direct;

	function automatic logic [HOST_BITS-1:0] advance(
		input logic [HOST_BITS-1:0] h,
		input logic [HOST_BITS-1:0] pool
	);
		logic [HOST_BITS-1:0] r;
		if (h >= pool) begin
			r = HOST_BITS'(1);
		end else begin
			r = h + HOST_BITS'(1);
		end
		return r;
	endfunction

	function automatic logic [15:0] host16(input logic [HOST_BITS-1:0] h);
		logic [31:0] w;
		w = 32'(h);
		return w[15:0];
	endfunction

	// Effective pool size and own ID at the host width.
	assign pool_w        = 32'(pool_size_q);
	assign pool_raw      = pool_w[HOST_BITS-1:0];
	assign eff_pool      = (pool_raw == '0) ? HOST_BITS'(1) : pool_raw;
	assign own_w         = 32'(own_q);
	assign own_h         = own_w[HOST_BITS-1:0];
	assign own_nz        = (own_h != '0);
	assign own_probe_hit = own_nz && (own_h == cand_q);
	assign start_host    = ((next_host_q == '0) || (next_host_q > eff_pool))
		? HOST_BITS'(1) : next_host_q;

	// Request checks that do not need the row.
	assign req_own          = own_nz && (diff_q == 64'(own_h));
	assign req_out_of_range = ((diff_q >> HOST_BITS) != 64'd0);
	assign req_direct       = req_own || req_out_of_range;

	assign in_xfer      = in_valid && in_ready;
	assign drained      = (exited_q == issued_q);
	assign adv_ok       = found_q && !exhaust_q;
	assign result_move  = (state_q == ST_RESULT) && (!out_valid_q || out_ready);
	assign exit_ctl     = link_ctl[TABLE_DEPTH];
	assign exit_host    = link_host[TABLE_DEPTH];
	assign probe_exit   = exit_ctl.valid && (exit_ctl.op == OP_PROBE)
		&& ((state_q == ST_PROBE) || (state_q == ST_DRAIN));
	assign refresh_exit = exit_ctl.valid && (exit_ctl.op == OP_REFRESH)
		&& (state_q == ST_REQ_WAIT);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (kind == KIND_SOLICIT) begin
						state_d = ST_PROBE;
					end else if (kind == KIND_REQUEST) begin
						state_d = ST_REQ_ISSUE;
					end
				end
			end
			ST_PROBE: begin
				if (found_q || exhaust_q || (issued_q == PROBE_MAX)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drained) begin
					state_d = ST_RESULT;
				end
			end
			ST_REQ_ISSUE: begin
				state_d = req_direct ? ST_RESULT : ST_REQ_WAIT;
			end
			ST_REQ_WAIT: begin
				if (refresh_exit) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (result_move) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: input ready and the token issued into the row.
	always_comb begin
		in_ready     = 1'b0;
		iss_ctl      = '0;
		iss_ctl.op   = OP_PROBE;
		iss_host     = cand_q;
		iss_life     = grant_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (kind == KIND_TICK)) begin
					iss_ctl.valid = 1'b1;
					iss_ctl.op    = OP_TICK;
				end
			end
			ST_PROBE: begin
				if (!found_q && !exhaust_q && (issued_q != PROBE_MAX)) begin
					iss_ctl.valid = 1'b1;
					iss_ctl.op    = OP_PROBE;
					iss_ctl.hit   = own_probe_hit;
				end
			end
			ST_DRAIN: begin
				if (drained && adv_ok) begin
					iss_ctl.valid = 1'b1;
					iss_ctl.op    = OP_INSERT;
					iss_host      = found_host_q;
				end
			end
			ST_REQ_ISSUE: begin
				if (!req_direct) begin
					iss_ctl.valid = 1'b1;
					iss_ctl.op    = OP_REFRESH;
					iss_host      = diff_q[HOST_BITS-1:0];
				end
			end
			ST_REQ_WAIT, ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	assign link_ctl[0]  = iss_ctl;
	assign link_host[0] = iss_host;
	assign link_life[0] = iss_life;

	// The row of lease cells.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		alt_cell #(
			.HOST_BITS(HOST_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev_ctl (link_ctl[i]),
			.prev_host(link_host[i]),
			.prev_life(link_life[i]),
			.next_ctl (link_ctl[i+1]),
			.next_host(link_host[i+1]),
			.next_life(link_life[i+1])
		);
	end

	// Configuration writes; the port never stalls.
	assign cfg_ready = 1'b1;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= 16'd65535;
			grant_q     <= 8'd10;
			base_q      <= 64'd0;
			own_q       <= 16'd0;
			state_q     <= ST_IDLE;
			next_host_q <= HOST_BITS'(1);
			cand_q      <= HOST_BITS'(1);
			issued_q    <= '0;
			exited_q    <= '0;
			found_q     <= 1'b0;
			exhaust_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_POOL_SIZE: pool_size_q <= cfg_data[15:0];
					CFG_GRANT:     grant_q     <= cfg_data[7:0];
					CFG_BASE:      base_q      <= cfg_data;
					CFG_OWN_HOST:  own_q       <= cfg_data[15:0];
					default: begin
					end
				endcase
			end

			// A solicit starts its probe sequence.
			if (in_xfer && (kind == KIND_SOLICIT)) begin
				cand_q    <= start_host;
				issued_q  <= '0;
				exited_q  <= '0;
				found_q   <= 1'b0;
				exhaust_q <= 1'b0;
			end

			if (iss_ctl.valid && (iss_ctl.op == OP_PROBE)) begin
				cand_q   <= advance(cand_q, eff_pool);
				issued_q <= issued_q + CW'(1);
			end

			// Probes come back in issue order; the first with no hit wins.
			if (probe_exit) begin
				exited_q <= exited_q + CW'(1);
				if ((exited_q == '0) && !exit_ctl.saw_free) begin
					exhaust_q <= 1'b1;
				end else if (!exit_ctl.hit && !found_q && !exhaust_q) begin
					found_q <= 1'b1;
				end
			end

			if ((state_q == ST_DRAIN) && drained && adv_ok) begin
				next_host_q <= advance(found_host_q, eff_pool);
			end

			// Output register: filled from the holding register, emptied on transfer.
			if (result_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			client_q <= client_id;
			req_q    <= req_addr_low;
			diff_q   <= req_addr_low - base_q;
		end

		if (probe_exit && !found_q && !exhaust_q && exit_ctl.saw_free && !exit_ctl.hit) begin
			found_host_q <= exit_host;
		end

		// Result of a solicit once all probes are back.
		if ((state_q == ST_DRAIN) && drained) begin
			if (adv_ok) begin
				res_kind_q <= RK_ADVERTISE;
				res_addr_q <= base_q + 64'(found_host_q);
				res_host_q <= host16(found_host_q);
			end else begin
				res_kind_q <= RK_EXHAUSTED;
				res_addr_q <= 64'd0;
				res_host_q <= 16'd0;
			end
		end

		// Requests answered without a pass through the row.
		if (state_q == ST_REQ_ISSUE) begin
			res_addr_q <= req_q;
			if (req_own) begin
				res_kind_q <= RK_REPLY;
				res_host_q <= host16(own_h);
			end else begin
				res_kind_q <= RK_NAK;
				res_host_q <= 16'd0;
			end
		end

		// Request answered by the refresh token.
		if (refresh_exit) begin
			res_addr_q <= req_q;
			if (exit_ctl.hit) begin
				res_kind_q <= RK_REPLY;
				res_host_q <= host16(exit_host);
			end else begin
				res_kind_q <= RK_NAK;
				res_host_q <= 16'd0;
			end
		end

		if (result_move) begin
			out_kind_q   <= res_kind_q;
			out_client_q <= client_q;
			out_addr_q   <= res_addr_q;
			out_host_q   <= res_host_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign reply_kind     = out_kind_q;
	assign reply_client   = out_client_q;
	assign reply_addr_low = out_addr_q;
	assign reply_host     = out_host_q;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for address_lease_table_core: directed and random lease traffic.
// A small scoreboard class predicts every reply; depends on alt_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
	import alt_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
	localparam int WATCHDOG_LIMIT = 5000;
	// The fourth item kind is not used by the protocol and must be ignored.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  code;
		logic [47:0] client;
		logic [63:0] addr;
		logic [15:0] host;
	} lease_reply_t;

	// Shadow copy of the lease table and the queue of replies still owed by the block.
	class lease_scoreboard;
		logic [15:0] pool_size;
		logic [7:0] grant_life;
		logic [63:0] base_low;
		logic [15:0] own_host;
		bit lease_used[TABLE_DEPTH];
		logic [15:0] lease_host[TABLE_DEPTH];
		logic [7:0] lease_life[TABLE_DEPTH];
		logic [15:0] next_id;
		lease_reply_t owed_replies[$];
		int failures;

		function new();
			pool_size = 16'd65535;
			grant_life = 8'd10;
			base_low = '0;
			own_host = '0;
			next_id = 16'd1;
			failures = 0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				lease_used[i] = 1'b0;
			end
		endfunction

		function void write_reg(logic [7:0] idx, logic [63:0] data);
			case (idx)
				CFG_POOL_SIZE: pool_size = data[15:0];
				CFG_GRANT:     grant_life = data[7:0];
				CFG_BASE:      base_low = data;
				CFG_OWN_HOST:  own_host = data[15:0];
				default: ;
			endcase
		endfunction

		// A pool size of zero behaves as a pool of one ID.
		function logic [15:0] pool_limit();
			return (pool_size == 16'd0) ? 16'd1 : pool_size;
		endfunction

		function bit id_taken(logic [15:0] h);
			if (own_host != 16'd0 && own_host == h)
				return 1'b1;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (lease_used[i] && lease_host[i] == h)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function logic [15:0] step_id(logic [15:0] h, logic [15:0] pool);
			return (h >= pool) ? 16'd1 : h + 16'd1;
		endfunction

		// Solicit: find a free slot, then probe IDs from the pointer for a free one.
		function lease_reply_t grant_lease(logic [47:0] client);
			lease_reply_t r;
			logic [15:0] pool;
			logic [15:0] h;
			int slot;
			r.code = RK_EXHAUSTED;
			r.client = client;
			r.addr = '0;
			r.host = '0;
			pool = pool_limit();
			slot = -1;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (!lease_used[i] && slot < 0)
					slot = i;
			end
			if (slot < 0)
				return r;
			h = next_id;
			if (h == 16'd0 || h > pool)
				h = 16'd1;
			for (int i = 0; i <= TABLE_DEPTH; i++) begin
				if (!id_taken(h)) begin
					lease_used[slot] = 1'b1;
					lease_host[slot] = h;
					lease_life[slot] = grant_life;
					next_id = step_id(h, pool);
					r.code = RK_ADVERTISE;
					r.addr = base_low + {48'd0, h};
					r.host = h;
					return r;
				end
				h = step_id(h, pool);
			end
			return r;
		endfunction

		// Request: the own ID matches first, then the lowest valid entry.
		function lease_reply_t refresh_lease(logic [47:0] client, logic [63:0] addr);
			lease_reply_t r;
			logic [63:0] diff;
			diff = addr - base_low;
			r.client = client;
			r.addr = addr;
			if (own_host != 16'd0 && diff == {48'd0, own_host}) begin
				r.code = RK_REPLY;
				r.host = own_host;
				return r;
			end
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (lease_used[i] && {48'd0, lease_host[i]} == diff) begin
					if (lease_life[i] < LIFE_REFRESH_CAP)
						lease_life[i] = lease_life[i] + 8'd1;
					r.code = RK_REPLY;
					r.host = lease_host[i];
					return r;
				end
			end
			r.code = RK_NAK;
			r.host = '0;
			return r;
		endfunction

		// Tick: drop leases that run out; permanent ones never age.
		function void age_leases();
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (lease_used[i]) begin
					if (lease_life[i] <= 8'd1)
						lease_used[i] = 1'b0;
					else if (lease_life[i] != LIFE_PERMANENT)
						lease_life[i] = lease_life[i] - 8'd1;
				end
			end
		endfunction

		// Append a reply to the tail of the owed queue.
		function void owe_reply(lease_reply_t r);
			owed_replies = {owed_replies, r};
		endfunction

		function void note_item(logic [1:0] k, logic [47:0] client, logic [63:0] addr);
			case (k)
				KIND_SOLICIT: owe_reply(grant_lease(client));
				KIND_REQUEST: owe_reply(refresh_lease(client, addr));
				KIND_TICK:    age_leases();
				default: ;
			endcase
		endfunction

		function void check_reply(logic [1:0] code, logic [47:0] client, logic [63:0] addr,
				logic [15:0] host);
			lease_reply_t want;
			if (owed_replies.size() == 0) begin
				failures++;
				$display("%0t: unexpected reply kind %0d client %h addr %h host %0d",
					$time, code, client, addr, host);
				return;
			end
			want = owed_replies.pop_front();
			if (code !== want.code) begin
				failures++;
				$display("%0t: reply_kind expected %0d actual %0d", $time, want.code, code);
			end
			if (client !== want.client) begin
				failures++;
				$display("%0t: reply_client expected %h actual %h", $time, want.client, client);
			end
			if (addr !== want.addr) begin
				failures++;
				$display("%0t: reply_addr_low expected %h actual %h", $time, want.addr, addr);
			end
			if (host !== want.host) begin
				failures++;
				$display("%0t: reply_host expected %0d actual %0d", $time, want.host, host);
			end
		endfunction

		function int pending_count();
			return owed_replies.size();
		endfunction

		// Address of an ID that is currently leased, so requests mostly hit.
		function logic [63:0] some_leased_addr();
			logic [15:0] ids[$];
			if (own_host != 16'd0)
				ids = {ids, own_host};
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (lease_used[i])
					ids = {ids, lease_host[i]};
			end
			if (ids.size() == 0)
				return base_low + 64'd1;
			return base_low + {48'd0, ids[$urandom_range(0, ids.size() - 1)]};
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [47:0] client_id;
	logic [63:0] req_addr_low;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  reply_kind;
	logic [47:0] reply_client;
	logic [63:0] reply_addr_low;
	logic [15:0] reply_host;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [63:0] cfg_data;

	lease_scoreboard board;
	bit no_gap;
	int stalled_cycles;

	address_lease_table_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.client_id     (client_id),
		.req_addr_low  (req_addr_low),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.reply_kind    (reply_kind),
		.reply_client  (reply_client),
		.reply_addr_low(reply_addr_low),
		.reply_host    (reply_host),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Every transfer is seen here, with the values that stood before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_reply(reply_kind, reply_client, reply_addr_low, reply_host);
			if (in_valid && in_ready)
				board.note_item(kind, client_id, req_addr_low);
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
		end
	end

	// The run ends with a failure if no transfer happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL address_lease_table_core");
				$finish;
			end
		end
	end

	// Result side: windows of readiness and stalls, mostly short, some long.
	initial begin
		int n;
		int r;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				out_ready <= 1'b1;
				n = $urandom_range(50, 300);
			end else if (r < 55) begin
				out_ready <= 1'b1;
				n = $urandom_range(1, 4);
			end else if (r < 90) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 3);
			end else if (r < 97) begin
				out_ready <= 1'b0;
				n = $urandom_range(4, 15);
			end else begin
				out_ready <= 1'b0;
				n = $urandom_range(30, 120);
			end
			repeat (n) @(posedge clk);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gap || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [47:0] pick_client();
		int r;
		logic [63:0] w;
		r = $urandom_range(0, 99);
		w = {$urandom, $urandom};
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return w[47:0];
	endfunction

	function automatic logic [63:0] pick_request_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return board.some_leased_addr();
		if (r < 75)
			return board.base_low + 64'($urandom_range(0, int'(board.pool_limit()) + 2));
		if (r < 85)
			return board.base_low + 64'h1_0000 + 64'($urandom_range(0, 1000));
		return {$urandom, $urandom};
	endfunction

	// One input transfer; valid stays high across back-to-back items.
	task automatic send_item(input logic [1:0] k, input logic [47:0] c, input logic [63:0] a);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		client_id <= c;
		req_addr_low <= a;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Hold the input off until every owed reply has come back.
	task automatic drain_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_count() != 0) @(posedge clk);
	endtask

	// Ticks leave no reply, so give the row time to empty as well.
	task automatic settle();
		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] pool, input logic [7:0] grant,
			input logic [63:0] base, input logic [15:0] own);
		logic [7:0] idx[4];
		logic [63:0] val[4];
		idx[0] = CFG_POOL_SIZE;
		idx[1] = CFG_GRANT;
		idx[2] = CFG_BASE;
		idx[3] = CFG_OWN_HOST;
		val[0] = {48'd0, pool};
		val[1] = {56'd0, grant};
		val[2] = base;
		val[3] = {48'd0, own};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// One setting of the registers followed by a random mix of items.
	task automatic run_phase(input logic [15:0] pool, input logic [7:0] grant,
			input logic [63:0] base, input logic [15:0] own, input int sol_pct,
			input int req_pct, input int count, input int flush_ticks);
		int r;
		logic [1:0] k;
		settle();
		program_regs(pool, grant, base, own);
		for (int n = 0; n < count; n++) begin
			no_gap = (n < 30);
			if (n == count / 2)
				drain_replies();
			r = $urandom_range(0, 99);
			if (r < sol_pct)
				k = KIND_SOLICIT;
			else if (r < sol_pct + req_pct)
				k = KIND_REQUEST;
			else if (r < 98)
				k = KIND_TICK;
			else
				k = KIND_UNUSED;
			send_item(k, pick_client(), pick_request_addr());
		end
		// Back-to-back ticks age out everything that is not permanent.
		no_gap = 1'b1;
		for (int n = 0; n < flush_ticks; n++) begin
			send_item(KIND_TICK, pick_client(), pick_request_addr());
		end
		no_gap = 1'b0;
	endtask

	initial begin
		logic [15:0] rand_pool;
		board = new();
		no_gap = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_SOLICIT;
		client_id <= '0;
		req_addr_low <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_POOL_SIZE;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: first leases, hits, misses, tick and the unused kind.
		send_item(KIND_SOLICIT, 48'd0, 64'd0);
		send_item(KIND_SOLICIT, '1, '1);
		send_item(KIND_REQUEST, 48'h5555_5555_5555, 64'd1);
		send_item(KIND_REQUEST, 48'hAAAA_AAAA_AAAA, '1);
		send_item(KIND_REQUEST, 48'd123, 64'd0);
		send_item(KIND_REQUEST, 48'd7, 64'h1_0000);
		send_item(KIND_TICK, 48'd0, 64'd0);
		send_item(KIND_UNUSED, '1, '1);

		// Tiny pool with the own ID inside it and a base that wraps around.
		settle();
		program_regs(16'd3, 8'd1, '1, 16'd2);
		send_item(KIND_SOLICIT, 48'h0000_0000_0001, 64'd0);
		send_item(KIND_SOLICIT, 48'h8000_0000_0000, 64'd0);
		send_item(KIND_REQUEST, 48'h1234_5678_9abc, 64'd1);
		send_item(KIND_REQUEST, 48'h0fed_cba9_8765, 64'd2);
		send_item(KIND_TICK, 48'd0, 64'd0);
		send_item(KIND_TICK, 48'd0, 64'd0);
		send_item(KIND_SOLICIT, 48'h0000_0000_0002, 64'd0);

		// A pool size of zero, which acts as one.
		settle();
		program_regs(16'd0, 8'd1, 64'h8000_0000_0000_0000, 16'd0);
		send_item(KIND_SOLICIT, 48'h0000_0000_0003, 64'd0);
		send_item(KIND_TICK, 48'd0, 64'd0);
		send_item(KIND_SOLICIT, 48'h0000_0000_0004, 64'd0);
		send_item(KIND_REQUEST, 48'h0000_0000_0005, 64'h8000_0000_0000_0001);

		run_phase(16'd65535, 8'd10, {$urandom, $urandom}, 16'd0, 35, 40, 240, 0);
		run_phase(16'd1, 8'd1, 64'd0, 16'd0, 45, 30, 150, 0);
		run_phase(16'd5, 8'd30, 64'hFFFF_FFFF_FFFF_FFFE, 16'd3, 40, 40, 220, 0);
		run_phase(16'd100, 8'd60, {$urandom, $urandom}, 16'd50, 80, 15, 250, 0);
		run_phase(16'd70, 8'd2, {$urandom, $urandom}, 16'd0, 40, 30, 220, 0);
		rand_pool = 16'($urandom_range(2, 300));
		run_phase(rand_pool, 8'($urandom_range(1, 254)), {$urandom, $urandom},
			16'($urandom_range(0, int'(rand_pool))), 40, 35, 220, 0);
		run_phase(16'd65535, 8'd254, '1, 16'd65535, 25, 45, 220, 256);
		// Lifetime 255 makes leases permanent.
		run_phase(16'd20, 8'd255, {$urandom, $urandom}, 16'd7, 35, 40, 180, 0);

		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.failures == 0 && board.pending_count() == 0)
			$display("PASS address_lease_table_core");
		else
			$display("FAIL address_lease_table_core");
		$finish;
	end

endmodule
